// ----- src/tacp_pkg.sv -----
// Shared types, constants and saturation helpers of the turn angle cascade controller.
`default_nettype none

package tacp_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_ANGLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_KP     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_KI     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_KD     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SPEED    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DONE_BAND    = 3'd6;

   localparam logic [31:0] TARGET_ANGLE_RESET = 32'd0;
   localparam logic [23:0] ANGLE_KP_RESET     = 24'd27525;
   localparam logic [23:0] ANGLE_KI_RESET     = 24'd98;
   localparam logic [23:0] ANGLE_KD_RESET     = 24'd65536;
   localparam logic [30:0] MAX_SPEED_RESET    = 31'h7FFF_FFFF;
   localparam logic [30:0] MIN_SPEED_RESET    = 31'd0;
   localparam logic [30:0] DONE_BAND_RESET    = 31'd65536;

   // wheel derivative weight 0.005 in Q8.16
   localparam logic [23:0] WHEEL_D_COEF = 24'd328;
   // half an LSB at Q16.16 for round to nearest
   localparam logic [71:0] ROUND_HALF   = 72'd32768;

   typedef struct packed {
      logic [31:0] target_angle;
      logic [23:0] angle_kp;
      logic [23:0] angle_ki;
      logic [23:0] angle_kd;
      logic [30:0] max_speed;
      logic [30:0] min_speed;
      logic [30:0] done_band;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HERR,
      ST_OPND,
      ST_MLO,
      ST_MHI,
      ST_MACC,
      ST_RND,
      ST_CMD,
      ST_CLAMP,
      ST_CLEAR,
      ST_WERR,
      ST_WUPD,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_HERR,
      OP_OPND,
      OP_MLO,
      OP_MHI,
      OP_MACC,
      OP_RND,
      OP_CMD,
      OP_CLAMP,
      OP_CLEAR,
      OP_WERR,
      OP_WUPD,
      OP_OUT
   } op_type;

   typedef enum logic [2:0] {
      TERM_P,
      TERM_I,
      TERM_D,
      TERM_LEFT,
      TERM_RIGHT
   } term_type;

   typedef struct packed {
      op_type   op;
      term_type term;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
      logic signed [31:0] r;
      if (v > 60'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -60'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      logic signed [47:0] r;
      if (v > 49'sd140737488355327) begin
         r = 48'sh7FFF_FFFF_FFFF;
      end else if (v < -49'sd140737488355328) begin
         r = 48'sh8000_0000_0000;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/turn_angle_cascade_pid.sv -----
// Top level of the cascaded heading and wheel-speed turn controller.
// One request word per control tick carries the measured heading and both wheel speeds;
// one response word returns turn_done and the left and right drive values.
// The heading PID (P, I, D terms) and the two incremental wheel PIDs share one 24x24
// multiplier, two passes per term, so a tick runs as a sequence of steps:
// a turning tick runs HERR, the P, I and D terms, CMD, CLAMP, both wheel updates and OUT;
// a tick that ends the turn (error inside the done band) runs HERR, the P, I and D terms, CMD, CLEAR and OUT.
// One tick is worked on at a time: req_stall is low only while the sequencer is idle,
// so the block takes no new request word until the current tick has left OUT.
// The response sits in an output register; the next request is accepted while it waits.
// If rsp_stall holds that register, the sequencer waits at its last step with the new
// result and moves on once the held word is taken.
// Reset clears all loop state and the response valid and loads the register defaults.
// Configuration registers are written through csr_wr_en, csr_index and csr_wr_data, one write per cycle;
// the user must write only while no tick is in progress (not enforced by the block); unused indexes are ignored.
`default_nettype none

module turn_angle_cascade_pid (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [31:0]               req_actual_angle,
   input  wire logic signed [31:0]               req_left_speed,
   input  wire logic signed [31:0]               req_right_speed,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_turn_done,
   output logic signed [31:0]                    rsp_left_drive,
   output logic signed [31:0]                    rsp_right_drive,
   input  wire logic                             csr_wr_en,
   input  wire logic [tacp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tacp_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import tacp_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tacp_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tacp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   tacp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_actual_angle (req_actual_angle),
      .req_left_speed   (req_left_speed),
      .req_right_speed  (req_right_speed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_turn_done    (rsp_turn_done),
      .rsp_left_drive   (rsp_left_drive),
      .rsp_right_drive  (rsp_right_drive)
   );

endmodule

`default_nettype wire

// ----- src/tacp_regs.sv -----
// Configuration register file of the turn angle cascade controller.
`default_nettype none

module tacp_regs (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [tacp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tacp_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output tacp_pkg::cfg_type                   cfg
);
   import tacp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_ANGLE: cfg_in.target_angle = csr_wr_data;
            REG_ANGLE_KP:     cfg_in.angle_kp     = csr_wr_data[23:0];
            REG_ANGLE_KI:     cfg_in.angle_ki     = csr_wr_data[23:0];
            REG_ANGLE_KD:     cfg_in.angle_kd     = csr_wr_data[23:0];
            REG_MAX_SPEED:    cfg_in.max_speed    = csr_wr_data[30:0];
            REG_MIN_SPEED:    cfg_in.min_speed    = csr_wr_data[30:0];
            REG_DONE_BAND:    cfg_in.done_band    = csr_wr_data[30:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_angle <= TARGET_ANGLE_RESET;
         cfg_ff.angle_kp     <= ANGLE_KP_RESET;
         cfg_ff.angle_ki     <= ANGLE_KI_RESET;
         cfg_ff.angle_kd     <= ANGLE_KD_RESET;
         cfg_ff.max_speed    <= MAX_SPEED_RESET;
         cfg_ff.min_speed    <= MIN_SPEED_RESET;
         cfg_ff.done_band    <= DONE_BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/tacp_ctrl.sv -----
// Sequencer of the turn angle cascade controller: steps the datapath through one tick.
`default_nettype none

module tacp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  tacp_pkg::dp_status_type      status,
   output tacp_pkg::dp_cmd_type         cmd
);
   import tacp_pkg::*;

   state_type state_ff;
   state_type state_in;
   term_type  term_ff;
   term_type  term_in;

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_HERR;
            end
         end
         ST_HERR: begin
            state_in = ST_OPND;
            term_in  = TERM_P;
         end
         ST_OPND: state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_MACC;
         ST_MACC: state_in = ST_RND;
         ST_RND: begin
            case (term_ff)
               TERM_P: begin
                  state_in = ST_OPND;
                  term_in  = TERM_I;
               end
               TERM_I: begin
                  state_in = ST_OPND;
                  term_in  = TERM_D;
               end
               TERM_D:  state_in = ST_CMD;
               default: state_in = ST_WUPD;
            endcase
         end
         ST_CMD: begin
            state_in = status.done ? ST_CLEAR : ST_CLAMP;
         end
         ST_CLEAR: state_in = ST_OUT;
         ST_CLAMP: begin
            state_in = ST_WERR;
            term_in  = TERM_LEFT;
         end
         ST_WERR: state_in = ST_OPND;
         ST_WUPD: begin
            if (term_ff == TERM_LEFT) begin
               state_in = ST_WERR;
               term_in  = TERM_RIGHT;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.term  = term_ff;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.op    = req_valid ? OP_LOAD : OP_NONE;
         end
         ST_HERR:  cmd.op = OP_HERR;
         ST_OPND:  cmd.op = OP_OPND;
         ST_MLO:   cmd.op = OP_MLO;
         ST_MHI:   cmd.op = OP_MHI;
         ST_MACC:  cmd.op = OP_MACC;
         ST_RND:   cmd.op = OP_RND;
         ST_CMD:   cmd.op = OP_CMD;
         ST_CLEAR: cmd.op = OP_CLEAR;
         ST_CLAMP: cmd.op = OP_CLAMP;
         ST_WERR:  cmd.op = OP_WERR;
         ST_WUPD:  cmd.op = OP_WUPD;
         ST_OUT:   cmd.op = status.out_free ? OP_OUT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= TERM_P;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/tacp_dp.sv -----
// Datapath of the turn angle cascade controller: loop state, shared multiplier, result word.
`default_nettype none

module tacp_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  tacp_pkg::cfg_type           cfg,
   input  tacp_pkg::dp_cmd_type        cmd,
   output tacp_pkg::dp_status_type     status,
   input  wire logic signed [31:0]     req_actual_angle,
   input  wire logic signed [31:0]     req_left_speed,
   input  wire logic signed [31:0]     req_right_speed,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_turn_done,
   output logic signed [31:0]          rsp_left_drive,
   output logic signed [31:0]          rsp_right_drive
);
   import tacp_pkg::*;

   logic signed [31:0] angle_ff, angle_in;
   logic signed [31:0] lspd_ff, lspd_in;
   logic signed [31:0] rspd_ff, rspd_in;

   logic signed [31:0] herr_ff, herr_in;
   logic signed [47:0] hsum_ff, hsum_in;
   logic signed [31:0] hlast_ff, hlast_in;
   logic signed [31:0] le1_ff, le1_in;
   logic signed [31:0] le2_ff, le2_in;
   logic signed [31:0] lacc_ff, lacc_in;
   logic signed [31:0] re1_ff, re1_in;
   logic signed [31:0] re2_ff, re2_in;
   logic signed [31:0] racc_ff, racc_in;

   logic               done_ff, done_in;
   logic [23:0]        gain_ff, gain_in;
   logic [47:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [47:0]        prod_ff, prod_in;
   logic [71:0]        macc_ff, macc_in;
   logic signed [59:0] term_ff, term_in;
   logic signed [31:0] cmd_ff, cmd_in;
   logic signed [31:0] werr_ff, werr_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_done_ff, rsp_done_in;
   logic signed [31:0] rsp_left_ff, rsp_left_in;
   logic signed [31:0] rsp_right_ff, rsp_right_in;

   logic signed [32:0] herr_diff;
   logic [31:0]        herr_abs;
   logic signed [47:0] hsum_next;
   logic               is_left;
   logic signed [31:0] sel_e1, sel_e2, sel_acc, sel_spd;
   logic signed [48:0] opnd_val, opnd_neg;
   logic [23:0]        opnd_gain;
   logic signed [59:0] lin_d, lin_w, lin;
   logic [23:0]        mul_b;
   logic [47:0]        mul_p;
   logic signed [59:0] rnd_r;
   logic signed [31:0] max_s, min_s, cmd_clamped;
   logic signed [33:0] wtgt, wdiff;
   logic signed [31:0] acc_next;

   assign herr_diff = $signed(33'($signed(cfg.target_angle))) - 33'(angle_ff);
   assign herr_abs  = herr_ff[31] ? 32'(-herr_ff) : 32'(herr_ff);
   assign hsum_next = sat48(49'(hsum_ff) + 49'(herr_ff));

   assign is_left = (cmd.term == TERM_LEFT);
   assign sel_e1  = is_left ? le1_ff  : re1_ff;
   assign sel_e2  = is_left ? le2_ff  : re2_ff;
   assign sel_acc = is_left ? lacc_ff : racc_ff;
   assign sel_spd = is_left ? lspd_ff : rspd_ff;

   always_comb begin
      opnd_val  = '0;
      opnd_gain = '0;
      case (cmd.term)
         TERM_P: begin
            opnd_val  = 49'(herr_ff);
            opnd_gain = cfg.angle_kp;
         end
         TERM_I: begin
            opnd_val  = 49'(hsum_ff);
            opnd_gain = cfg.angle_ki;
         end
         TERM_D: begin
            opnd_val  = 49'(herr_ff) - 49'(hlast_ff);
            opnd_gain = cfg.angle_kd;
         end
         TERM_LEFT, TERM_RIGHT: begin
            opnd_val  = 49'(werr_ff) - (49'(sel_e1) <<< 1) + 49'(sel_e2);
            opnd_gain = WHEEL_D_COEF;
         end
         default: begin
            opnd_val  = '0;
            opnd_gain = '0;
         end
      endcase
   end

   assign opnd_neg = -opnd_val;

   // 5*(e-e1) + 6*e
   assign lin_d = 60'(werr_ff) - 60'(sel_e1);
   assign lin_w = 60'(werr_ff);
   assign lin   = (lin_d <<< 2) + lin_d + (lin_w <<< 2) + (lin_w <<< 1);

   assign mul_b = (cmd.op == OP_MHI) ? mag_ff[47:24] : mag_ff[23:0];
   assign mul_p = 48'(gain_ff) * 48'(mul_b);

   assign rnd_r = $signed({4'b0000, macc_ff[71:16]});

   assign max_s = $signed({1'b0, cfg.max_speed});
   assign min_s = $signed({1'b0, cfg.min_speed});

   always_comb begin
      logic signed [31:0] c1;
      c1          = cmd_ff;
      cmd_clamped = cmd_ff;
      if (cmd_ff > 32'sd0) begin
         c1          = (cmd_ff > max_s) ? max_s : cmd_ff;
         cmd_clamped = (c1 < min_s) ? min_s : c1;
      end else if (cmd_ff < 32'sd0) begin
         c1          = (cmd_ff < -max_s) ? -max_s : cmd_ff;
         cmd_clamped = (c1 > -min_s) ? -min_s : c1;
      end
   end

   assign wtgt     = is_left ? -34'(cmd_ff) : 34'(cmd_ff);
   assign wdiff    = wtgt - 34'(sel_spd);
   assign acc_next = sat32(60'(sel_acc) + term_ff);

   always_comb begin
      angle_in  = angle_ff;
      lspd_in   = lspd_ff;
      rspd_in   = rspd_ff;
      herr_in   = herr_ff;
      hsum_in   = hsum_ff;
      hlast_in  = hlast_ff;
      le1_in    = le1_ff;
      le2_in    = le2_ff;
      lacc_in   = lacc_ff;
      re1_in    = re1_ff;
      re2_in    = re2_ff;
      racc_in   = racc_ff;
      done_in   = done_ff;
      gain_in   = gain_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      macc_in   = macc_ff;
      term_in   = term_ff;
      cmd_in    = cmd_ff;
      werr_in   = werr_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.op)
         OP_LOAD: begin
            angle_in = req_actual_angle;
            lspd_in  = req_left_speed;
            rspd_in  = req_right_speed;
         end
         OP_HERR: begin
            herr_in = sat32(60'(herr_diff));
            term_in = '0;
         end
         OP_OPND: begin
            gain_in = opnd_gain;
            neg_in  = opnd_val[48];
            mag_in  = opnd_val[48] ? opnd_neg[47:0] : opnd_val[47:0];
            macc_in = ROUND_HALF;
            if (cmd.term == TERM_P) begin
               hsum_in = hsum_next;
            end
            if (is_left || cmd.term == TERM_RIGHT) begin
               term_in = lin;
            end
         end
         OP_MLO: begin
            prod_in = mul_p;
            done_in = herr_abs < {1'b0, cfg.done_band};
         end
         OP_MHI: begin
            macc_in = macc_ff + {24'd0, prod_ff};
            prod_in = mul_p;
         end
         OP_MACC: begin
            macc_in = macc_ff + {prod_ff, 24'd0};
         end
         OP_RND: begin
            term_in = neg_ff ? term_ff - rnd_r : term_ff + rnd_r;
         end
         OP_CMD: begin
            cmd_in   = sat32(term_ff);
            hlast_in = herr_ff;
         end
         OP_CLEAR: begin
            hsum_in  = '0;
            hlast_in = '0;
            le1_in   = '0;
            le2_in   = '0;
            lacc_in  = '0;
            re1_in   = '0;
            re2_in   = '0;
            racc_in  = '0;
         end
         OP_CLAMP: begin
            cmd_in = cmd_clamped;
         end
         OP_WERR: begin
            werr_in = sat32(60'(wdiff));
         end
         OP_WUPD: begin
            if (is_left) begin
               lacc_in = acc_next;
               le2_in  = le1_ff;
               le1_in  = werr_ff;
            end else begin
               racc_in = acc_next;
               re2_in  = re1_ff;
               re1_in  = werr_ff;
            end
         end
         OP_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_done_in  = done_ff;
            rsp_left_in  = lacc_ff;
            rsp_right_in = racc_ff;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hsum_ff      <= '0;
         hlast_ff     <= '0;
         le1_ff       <= '0;
         le2_ff       <= '0;
         lacc_ff      <= '0;
         re1_ff       <= '0;
         re2_ff       <= '0;
         racc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hsum_ff      <= hsum_in;
         hlast_ff     <= hlast_in;
         le1_ff       <= le1_in;
         le2_ff       <= le2_in;
         lacc_ff      <= lacc_in;
         re1_ff       <= re1_in;
         re2_ff       <= re2_in;
         racc_ff      <= racc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff     <= angle_in;
      lspd_ff      <= lspd_in;
      rspd_ff      <= rspd_in;
      herr_ff      <= herr_in;
      done_ff      <= done_in;
      gain_ff      <= gain_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      macc_ff      <= macc_in;
      term_ff      <= term_in;
      cmd_ff       <= cmd_in;
      werr_ff      <= werr_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign status.done     = done_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_turn_done   = rsp_done_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;

endmodule

`default_nettype wire
